// ===== hdl/treble_booster_stereo_defines.svh =====
// assertion macros for the treble booster blocks
// expects clk and rst_n in the scope where a macro is used
`ifndef TREBLE_BOOSTER_STEREO_DEFINES_SVH
`define TREBLE_BOOSTER_STEREO_DEFINES_SVH
`ifndef SYNTHESIS
// condition holds in the same cycle
`define TBS_ASSERT_HOLDS(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("tbs check failed");
// condition leads to property in the next cycle
`define TBS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("tbs check failed");
`else
`define TBS_ASSERT_HOLDS(label, cond, prop)
`define TBS_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ===== hdl/tbs_pkg.sv =====
// shared types, constants and helper functions of the treble booster
// no dependencies; used by every other file of the block but the macros header
package tbs_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 24;
  localparam int TANH_DEPTH     = 1024;
  localparam int FRAC_BITS      = SAMPLE_BITS - 1;
  localparam int WORD_BITS      = 32;
  localparam int BOOST_BITS     = 16;
  localparam int WT_BITS        = 18;
  localparam int WT_SHIFT       = 16;
  localparam int TANH_ADDR_BITS = $clog2(TANH_DEPTH + 1);
  localparam int TANH_LOG2      = $clog2(TANH_DEPTH);
  localparam int TANH_SHIFT     = FRAC_BITS + 3 - TANH_LOG2;
  localparam int OPB_A          = (COEF_BITS > WT_BITS) ? COEF_BITS : WT_BITS;
  localparam int OPB_BITS       = (OPB_A > TANH_SHIFT) ? OPB_A : TANH_SHIFT;
  localparam int PROD_BITS      = WORD_BITS + OPB_BITS + 1;
  localparam int ACC_BITS       = PROD_BITS + 2;
  localparam int CFG_BITS       = (COEF_BITS > BOOST_BITS) ? COEF_BITS : BOOST_BITS;
  localparam int CFG_IDX_BITS   = 3;

  // reset values of the registers
  localparam logic [BOOST_BITS-1:0] BOOST_RESET = BOOST_BITS'(32768);
  localparam logic [COEF_BITS-1:0]  IN_HP_RESET  = COEF_BITS'(15775600);
  localparam logic [COEF_BITS-1:0]  OUT_HP_RESET = COEF_BITS'(16616300);
  localparam logic [COEF_BITS-1:0]  BRIGHT_RESET = COEF_BITS'(2845900);
  localparam logic [COEF_BITS-1:0]  TOP_RESET    = COEF_BITS'(11875600);

  // weight curves, Q.16 base plus slope times boost (minus for wlow)
  localparam logic [31:0] KMIX_BASE   = 32'd38011;
  localparam logic [31:0] KMIX_SLOPE  = 32'd11796;
  localparam logic [31:0] WLOW_BASE   = 32'd27525;
  localparam logic [31:0] WLOW_SLOPE  = 32'd13107;
  localparam logic [31:0] WHIGH_BASE  = 32'd72090;
  localparam logic [31:0] WHIGH_SLOPE = 32'd108134;
  localparam logic [31:0] GAIN_BASE   = 32'd68813;
  localparam logic [31:0] GAIN_SLOPE  = 32'd134349;
  localparam logic [31:0] GAIN_SQ     = 32'd55706;
  localparam logic [31:0] POS_BASE    = 32'd51118;
  localparam logic [31:0] POS_SLOPE   = 32'd36045;
  localparam logic [31:0] NEG_BASE    = 32'd40632;
  localparam logic [31:0] NEG_SLOPE   = 32'd27525;
  localparam logic [31:0] LEVEL_BASE  = 32'd45875;
  localparam logic [31:0] LEVEL_SLOPE = 32'd26214;
  localparam logic [31:0] BIAS_SCALE  = 32'd103079215;
  localparam int          BIAS_SHIFT  = 48 - FRAC_BITS;

  localparam logic [63:0] QONE = 64'h1_0000_0000;

  // table step 16 / depth in Q.32
  localparam logic [63:0] TANH_STEP = (64'd16 << 32) / TANH_DEPTH;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COEF_BITS-1:0]          coef_t;
  typedef logic [WT_BITS-1:0]            weight_t;
  typedef logic [OPB_BITS-1:0]           opb_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [FRAC_BITS-1:0]          tanh_entry_t;
  typedef tanh_entry_t                   tanh_tab_t [TANH_DEPTH+1];

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BOOST  = 3'd0,
    CFG_IN_HP  = 3'd1,
    CFG_OUT_HP = 3'd2,
    CFG_BRIGHT = 3'd3,
    CFG_TOP    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SH_COEF   = 2'd0,
    SH_WEIGHT = 2'd1,
    SH_TANH   = 2'd2
  } shift_t;

  typedef struct packed {
    weight_t kmix;
    weight_t wlow;
    weight_t whigh;
    weight_t gain;
    weight_t pos;
    weight_t neg;
    weight_t level;
    word_t   bias;
  } weights_t;

  typedef struct packed {
    logic    idle;
    logic    done;
    sample_t value;
  } lane_res_t;

  // saturate a wide accumulator to a signed word
  function automatic word_t sat_word(input acc_t v);
    logic hi_all, hi_none;
    hi_all  = &v[ACC_BITS-1:WORD_BITS-1];
    hi_none = ~|v[ACC_BITS-1:WORD_BITS-1];
    if (hi_all || hi_none) return v[WORD_BITS-1:0];
    else if (v[ACC_BITS-1]) return {1'b1, {(WORD_BITS-1){1'b0}}};
    else return {1'b0, {(WORD_BITS-1){1'b1}}};
  endfunction

  // saturate a word to the sample range
  function automatic sample_t sat_sample(input word_t v);
    logic hi_all, hi_none;
    hi_all  = &v[WORD_BITS-1:FRAC_BITS];
    hi_none = ~|v[WORD_BITS-1:FRAC_BITS];
    if (hi_all || hi_none) return v[SAMPLE_BITS-1:0];
    else if (v[WORD_BITS-1]) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  // base plus rounded slope times boost, Q.16
  function automatic weight_t wq(input logic [31:0] c0, input logic [31:0] c1,
                                 input logic [BOOST_BITS-1:0] b);
    logic [47:0] p;
    p = 48'(c1) * 48'(b) + 48'd32768;
    return WT_BITS'(48'(c0) + (p >> BOOST_BITS));
  endfunction

  // rounded Q32.32 product
  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'h8000_0000) >> 32;
  endfunction

  // shift and subtract quotient, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh table over arguments 0..8, built at elaboration
  function automatic tanh_tab_t tanh_build();
    tanh_tab_t   tab;
    logic [63:0] tq, sum, term, r, e, base, num, val, cap;
    int unsigned kk;
    logic        have;
    tq   = TANH_STEP;
    sum  = QONE;
    term = QONE;
    cap  = (64'd1 << FRAC_BITS) - 64'd1;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(term * tq, 64'(n) << 32);
      if ((n & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    r = sum;
    for (int k = 0; k <= TANH_DEPTH; k++) begin
      kk   = k;
      e    = QONE;
      have = 1'b0;
      base = r;
      while (kk != 0) begin
        if ((kk & 1) != 0) begin
          e    = have ? mulq(e, base) : base;
          have = 1'b1;
        end
        kk = kk >> 1;
        if (kk != 0) base = mulq(base, base);
      end
      num = (e >= QONE) ? 64'd0 : QONE - e;
      val = udiv64(num << FRAC_BITS, QONE + e);
      tab[k] = (val > cap) ? cap[FRAC_BITS-1:0] : val[FRAC_BITS-1:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TABLE = tanh_build();

endpackage

// ===== hdl/tbs_in_if.sv =====
// request channel carrying one stereo input pair
// depends on tbs_pkg for the sample type
interface tbs_in_if;
  logic             valid;
  logic             ready;
  tbs_pkg::sample_t sample_left;
  tbs_pkg::sample_t sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

// ===== hdl/tbs_out_if.sv =====
// request channel carrying one processed stereo pair
// depends on tbs_pkg for the sample type
interface tbs_out_if;
  logic             valid;
  logic             ready;
  tbs_pkg::sample_t out_left;
  tbs_pkg::sample_t out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== hdl/tbs_weights.sv =====
// boost-dependent weights, gain, drive, level and bias
// depends on tbs_pkg; registered, the gain's squared term passes b2_r then wts_r
module tbs_weights (
  input  logic                           clk,
  input  logic [tbs_pkg::BOOST_BITS-1:0] boost,
  output tbs_pkg::weights_t              wts
);

  logic [tbs_pkg::BOOST_BITS-1:0] b2_r;
  logic [32:0]                    b2_full;
  logic [47:0]                    sq_term;
  logic [47:0]                    bias_prod;
  tbs_pkg::weights_t              wts_r;
  tbs_pkg::weights_t              wts_nxt;

  // boost squared, Q0.16
  assign b2_full = 33'(boost) * 33'(boost) + 33'd32768;

  always_comb begin
    sq_term   = 48'(tbs_pkg::GAIN_SQ) * 48'(b2_r) + 48'd32768;
    bias_prod = 48'(tbs_pkg::BIAS_SCALE) * (48'd65536 + 48'(boost))
              + (48'd1 << (tbs_pkg::BIAS_SHIFT - 1));
    wts_nxt.kmix  = tbs_pkg::wq(tbs_pkg::KMIX_BASE, tbs_pkg::KMIX_SLOPE, boost);
    wts_nxt.wlow  = tbs_pkg::WT_BITS'(tbs_pkg::WLOW_BASE
                  - 32'((48'(tbs_pkg::WLOW_SLOPE) * 48'(boost) + 48'd32768) >> 16));
    wts_nxt.whigh = tbs_pkg::wq(tbs_pkg::WHIGH_BASE, tbs_pkg::WHIGH_SLOPE, boost);
    wts_nxt.gain  = tbs_pkg::wq(tbs_pkg::GAIN_BASE, tbs_pkg::GAIN_SLOPE, boost)
                  + tbs_pkg::WT_BITS'(sq_term >> 16);
    wts_nxt.pos   = tbs_pkg::wq(tbs_pkg::POS_BASE, tbs_pkg::POS_SLOPE, boost);
    wts_nxt.neg   = tbs_pkg::wq(tbs_pkg::NEG_BASE, tbs_pkg::NEG_SLOPE, boost);
    wts_nxt.level = tbs_pkg::wq(tbs_pkg::LEVEL_BASE, tbs_pkg::LEVEL_SLOPE, boost);
    wts_nxt.bias  = -$signed(tbs_pkg::WORD_BITS'(bias_prod >> tbs_pkg::BIAS_SHIFT));
  end

  always_ff @(posedge clk) begin
    b2_r  <= b2_full[31:16];
    wts_r <= wts_nxt;
  end

  assign wts = wts_r;

endmodule

// ===== hdl/tbs_lane.sv =====
// one channel of the booster: sequencer around a single shared multiplier
// depends on tbs_pkg and the assertion macros header
`include "treble_booster_stereo_defines.svh"

module tbs_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tbs_pkg::sample_t   sample,
  input  logic               take,
  input  tbs_pkg::coef_t     in_coef,
  input  tbs_pkg::coef_t     out_coef,
  input  tbs_pkg::coef_t     bright_coef,
  input  tbs_pkg::coef_t     top_coef,
  input  tbs_pkg::weights_t  wts,
  output tbs_pkg::lane_res_t res
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PRE  = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_ACC  = 8'b0000_1000,
    ST_LUT0 = 8'b0001_0000,
    ST_LUT1 = 8'b0010_0000,
    ST_LUT2 = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } lane_state_t;

  typedef enum logic [3:0] {
    STEP_IHP   = 4'd0,
    STEP_BLP   = 4'd1,
    STEP_HIGH  = 4'd2,
    STEP_WLOW  = 4'd3,
    STEP_WHIGH = 4'd4,
    STEP_GAIN  = 4'd5,
    STEP_DRIVE = 4'd6,
    STEP_TANH  = 4'd7,
    STEP_OHP   = 4'd8,
    STEP_TLP   = 4'd9,
    STEP_LEVEL = 4'd10
  } step_t;

  localparam tbs_pkg::prod_t HALF_COEF =
    tbs_pkg::PROD_BITS'(1) << (tbs_pkg::COEF_BITS - 1);
  localparam tbs_pkg::prod_t HALF_WT =
    tbs_pkg::PROD_BITS'(1) << (tbs_pkg::WT_SHIFT - 1);
  localparam tbs_pkg::prod_t HALF_TANH =
    tbs_pkg::PROD_BITS'(1) << (tbs_pkg::TANH_SHIFT - 1);
  localparam logic [tbs_pkg::TANH_ADDR_BITS-1:0] ADDR_LAST =
    tbs_pkg::TANH_ADDR_BITS'(tbs_pkg::TANH_DEPTH);

  lane_state_t state_r, state_nxt;
  step_t       step_r;

  // filter state
  tbs_pkg::word_t ihx_r, ihy_r, ohx_r, ohy_r, blp_r, tlp_r;
  // working values
  tbs_pkg::word_t x_r, y_r, high_r, t_r, v_r;
  tbs_pkg::word_t op_a_r, add_r;
  tbs_pkg::opb_t  op_b_r;
  logic           sub_r;
  tbs_pkg::shift_t sh_r;
  tbs_pkg::prod_t prod_r;
  logic [tbs_pkg::TANH_ADDR_BITS-1:0] addr_r;
  logic [tbs_pkg::TANH_SHIFT-1:0]     lo_r;
  logic                               neg_r;
  tbs_pkg::tanh_entry_t               t0_r, t1_r;
  tbs_pkg::sample_t                   out_r;

  tbs_pkg::word_t  pre_a, pre_add, diff, acc_res, tanh_res;
  tbs_pkg::opb_t   pre_b;
  logic            pre_sub;
  tbs_pkg::shift_t pre_sh;
  tbs_pkg::prod_t  rnd;
  tbs_pkg::acc_t   acc_sum;
  logic [tbs_pkg::WORD_BITS:0] mag;

  // operand selection for the current step
  always_comb begin
    diff = $signed({{(tbs_pkg::WORD_BITS-tbs_pkg::FRAC_BITS){1'b0}}, t1_r})
         - $signed({{(tbs_pkg::WORD_BITS-tbs_pkg::FRAC_BITS){1'b0}}, t0_r});
    pre_a   = v_r;
    pre_b   = '0;
    pre_add = '0;
    pre_sub = 1'b0;
    pre_sh  = tbs_pkg::SH_WEIGHT;
    unique case (step_r)
      STEP_IHP: begin
        pre_a  = tbs_pkg::sat_word(tbs_pkg::ACC_BITS'(ihy_r) + tbs_pkg::ACC_BITS'(x_r)
                                   - tbs_pkg::ACC_BITS'(ihx_r));
        pre_b  = tbs_pkg::OPB_BITS'(in_coef);
        pre_sh = tbs_pkg::SH_COEF;
      end
      STEP_BLP: begin
        pre_a   = tbs_pkg::sat_word(tbs_pkg::ACC_BITS'(y_r) - tbs_pkg::ACC_BITS'(blp_r));
        pre_b   = tbs_pkg::OPB_BITS'(bright_coef);
        pre_add = blp_r;
        pre_sh  = tbs_pkg::SH_COEF;
      end
      STEP_HIGH: begin
        pre_a   = blp_r;
        pre_b   = tbs_pkg::OPB_BITS'(wts.kmix);
        pre_add = y_r;
        pre_sub = 1'b1;
      end
      STEP_WLOW: begin
        pre_a = blp_r;
        pre_b = tbs_pkg::OPB_BITS'(wts.wlow);
      end
      STEP_WHIGH: begin
        pre_a   = high_r;
        pre_b   = tbs_pkg::OPB_BITS'(wts.whigh);
        pre_add = t_r;
      end
      STEP_GAIN: begin
        pre_a   = v_r;
        pre_b   = tbs_pkg::OPB_BITS'(wts.gain);
        pre_add = wts.bias;
      end
      STEP_DRIVE: begin
        pre_a = v_r;
        pre_b = v_r[tbs_pkg::WORD_BITS-1] ? tbs_pkg::OPB_BITS'(wts.neg)
                                          : tbs_pkg::OPB_BITS'(wts.pos);
      end
      STEP_TANH: begin
        pre_a   = diff;
        pre_b   = tbs_pkg::OPB_BITS'(lo_r);
        pre_add = tbs_pkg::WORD_BITS'(t0_r);
        pre_sh  = tbs_pkg::SH_TANH;
      end
      STEP_OHP: begin
        pre_a  = tbs_pkg::sat_word(tbs_pkg::ACC_BITS'(ohy_r) + tbs_pkg::ACC_BITS'(v_r)
                                   - tbs_pkg::ACC_BITS'(ohx_r));
        pre_b  = tbs_pkg::OPB_BITS'(out_coef);
        pre_sh = tbs_pkg::SH_COEF;
      end
      STEP_TLP: begin
        pre_a   = tbs_pkg::sat_word(tbs_pkg::ACC_BITS'(y_r) - tbs_pkg::ACC_BITS'(tlp_r));
        pre_b   = tbs_pkg::OPB_BITS'(top_coef);
        pre_add = tlp_r;
        pre_sh  = tbs_pkg::SH_COEF;
      end
      STEP_LEVEL: begin
        pre_a = tlp_r;
        pre_b = tbs_pkg::OPB_BITS'(wts.level);
      end
      default: ;
    endcase
  end

  // round the product, add or subtract, saturate
  always_comb begin
    unique case (sh_r)
      tbs_pkg::SH_COEF:   rnd = (prod_r + HALF_COEF) >>> tbs_pkg::COEF_BITS;
      tbs_pkg::SH_TANH:   rnd = (prod_r + HALF_TANH) >>> tbs_pkg::TANH_SHIFT;
      default:            rnd = (prod_r + HALF_WT) >>> tbs_pkg::WT_SHIFT;
    endcase
    if (sub_r) acc_sum = tbs_pkg::ACC_BITS'(add_r) - tbs_pkg::ACC_BITS'(rnd);
    else acc_sum = tbs_pkg::ACC_BITS'(add_r) + tbs_pkg::ACC_BITS'(rnd);
    acc_res  = tbs_pkg::sat_word(acc_sum);
    tanh_res = neg_r ? -acc_res : acc_res;
    mag = v_r[tbs_pkg::WORD_BITS-1] ? -((tbs_pkg::WORD_BITS+1)'(v_r))
                                    : (tbs_pkg::WORD_BITS+1)'(v_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_PRE;
      ST_PRE:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (step_r == STEP_DRIVE) state_nxt = ST_LUT0;
        else if (step_r == STEP_LEVEL) state_nxt = ST_DONE;
        else state_nxt = ST_PRE;
      end
      ST_LUT0: state_nxt = ST_LUT1;
      ST_LUT1: state_nxt = ST_LUT2;
      ST_LUT2: state_nxt = ST_PRE;
      ST_DONE: if (take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_IHP;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && start) step_r <= STEP_IHP;
      else if (state_r == ST_ACC && step_r != STEP_LEVEL) step_r <= step_t'(step_r + 4'd1);
    end
  end

  // filter state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ihx_r <= '0;
      ihy_r <= '0;
      ohx_r <= '0;
      ohy_r <= '0;
      blp_r <= '0;
      tlp_r <= '0;
    end else begin
      if (state_r == ST_PRE && step_r == STEP_IHP) ihx_r <= x_r;
      if (state_r == ST_PRE && step_r == STEP_OHP) ohx_r <= v_r;
      if (state_r == ST_ACC) begin
        unique case (step_r)
          STEP_IHP: ihy_r <= acc_res;
          STEP_BLP: blp_r <= acc_res;
          STEP_OHP: ohy_r <= acc_res;
          STEP_TLP: tlp_r <= acc_res;
          default:  ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) x_r <= tbs_pkg::WORD_BITS'(sample);
    if (state_r == ST_PRE) begin
      op_a_r <= pre_a;
      op_b_r <= pre_b;
      add_r  <= pre_add;
      sub_r  <= pre_sub;
      sh_r   <= pre_sh;
    end
    if (state_r == ST_MUL) prod_r <= tbs_pkg::PROD_BITS'($signed(op_a_r) * $signed({1'b0, op_b_r}));
    if (state_r == ST_ACC) begin
      unique case (step_r)
        STEP_IHP, STEP_OHP:              y_r    <= acc_res;
        STEP_HIGH:                       high_r <= acc_res;
        STEP_WLOW:                       t_r    <= acc_res;
        STEP_WHIGH, STEP_GAIN, STEP_DRIVE: v_r  <= acc_res;
        STEP_TANH:                       v_r    <= tanh_res;
        STEP_LEVEL:                      out_r  <= tbs_pkg::sat_sample(acc_res);
        default:                         ;
      endcase
    end
    // table address from the clip argument, last entry beyond range
    if (state_r == ST_LUT0) begin
      neg_r <= v_r[tbs_pkg::WORD_BITS-1];
      if ((mag >> tbs_pkg::TANH_SHIFT) >= (tbs_pkg::WORD_BITS+1)'(tbs_pkg::TANH_DEPTH)) begin
        addr_r <= ADDR_LAST;
        lo_r   <= '0;
      end else begin
        addr_r <= tbs_pkg::TANH_ADDR_BITS'(mag >> tbs_pkg::TANH_SHIFT);
        lo_r   <= mag[tbs_pkg::TANH_SHIFT-1:0];
      end
    end
    if (state_r == ST_LUT1) begin
      t0_r <= tbs_pkg::TANH_TABLE[addr_r];
      if (addr_r != ADDR_LAST) addr_r <= addr_r + 1'b1;
    end
    if (state_r == ST_LUT2) t1_r <= tbs_pkg::TANH_TABLE[addr_r];
  end

  assign res.idle  = (state_r == ST_IDLE);
  assign res.done  = (state_r == ST_DONE);
  assign res.value = out_r;

  // checks
  `TBS_ASSERT_HOLDS(a_start_idle, start, state_r == ST_IDLE)
  `TBS_ASSERT_NEXT(a_start_seq, start, state_r == ST_PRE && step_r == STEP_IHP)
  `TBS_ASSERT_HOLDS(a_take_done, take, state_r == ST_DONE)
  `TBS_ASSERT_NEXT(a_done_hold, state_r == ST_DONE && !take, state_r == ST_DONE && $stable(out_r))

endmodule

// ===== hdl/tbs_merge.sv =====
// joins the two lane results into the output register
// depends on tbs_pkg and tbs_out_if
module tbs_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  tbs_pkg::lane_res_t left_res,
  input  tbs_pkg::lane_res_t right_res,
  output logic               take,
  tbs_out_if.source          out_ch
);

  logic             valid_r;
  tbs_pkg::sample_t left_r, right_r;
  logic             load;

  // load once both lanes finish and the register is free
  assign load = left_res.done && right_res.done && (!valid_r || out_ch.ready);
  assign take = load;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (load) valid_r <= 1'b1;
    else if (out_ch.ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= left_res.value;
      right_r <= right_res.value;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.out_left  = left_r;
  assign out_ch.out_right = right_r;

endmodule

// ===== hdl/treble_booster_stereo.sv =====
// Stereo treble booster. Each request carries a left and right Q1.23 sample
// and gives one processed pair. The two channels run in separate lanes, each
// with one 32 x 25 multiplier stepped through eleven products, each taking
// the PRE, MUL and ACC states, plus the LUT0, LUT1 and LUT2 table states.
// A new pair is taken only once both lanes are idle, after the previous pair
// has moved into the output register, so pairs never overlap. Boost changes
// reach the weights via wts_r, the gain's squared term via b2_r first. Depends
// on tbs_pkg, the two channel interfaces, tbs_weights, tbs_lane and tbs_merge.
module treble_booster_stereo (
  input  logic                             clk,
  input  logic                             rst_n,
  tbs_in_if.sink                           in_ch,
  tbs_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [tbs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tbs_pkg::CFG_BITS-1:0]     cfg_data
);

  logic [tbs_pkg::BOOST_BITS-1:0] boost_r;
  tbs_pkg::coef_t     in_hp_r, out_hp_r, bright_r, top_r;
  tbs_pkg::weights_t  wts;
  tbs_pkg::lane_res_t left_res, right_res;
  logic               start, take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boost_r  <= tbs_pkg::BOOST_RESET;
      in_hp_r  <= tbs_pkg::IN_HP_RESET;
      out_hp_r <= tbs_pkg::OUT_HP_RESET;
      bright_r <= tbs_pkg::BRIGHT_RESET;
      top_r    <= tbs_pkg::TOP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbs_pkg::CFG_BOOST:  boost_r  <= cfg_data[tbs_pkg::BOOST_BITS-1:0];
        tbs_pkg::CFG_IN_HP:  in_hp_r  <= cfg_data[tbs_pkg::COEF_BITS-1:0];
        tbs_pkg::CFG_OUT_HP: out_hp_r <= cfg_data[tbs_pkg::COEF_BITS-1:0];
        tbs_pkg::CFG_BRIGHT: bright_r <= cfg_data[tbs_pkg::COEF_BITS-1:0];
        tbs_pkg::CFG_TOP:    top_r    <= cfg_data[tbs_pkg::COEF_BITS-1:0];
        default:             ;
      endcase
    end
  end

  // accept a request when both lanes are free
  assign in_ch.ready = left_res.idle && right_res.idle;
  assign start       = in_ch.valid && in_ch.ready;

  tbs_weights u_weights (
    .clk   (clk),
    .boost (boost_r),
    .wts   (wts)
  );

  tbs_lane u_lane_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .sample      (in_ch.sample_left),
    .take        (take),
    .in_coef     (in_hp_r),
    .out_coef    (out_hp_r),
    .bright_coef (bright_r),
    .top_coef    (top_r),
    .wts         (wts),
    .res         (left_res)
  );

  tbs_lane u_lane_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .sample      (in_ch.sample_right),
    .take        (take),
    .in_coef     (in_hp_r),
    .out_coef    (out_hp_r),
    .bright_coef (bright_r),
    .top_coef    (top_r),
    .wts         (wts),
    .res         (right_res)
  );

  tbs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .left_res  (left_res),
    .right_res (right_res),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule
